// ----- design/acmad_pkg.sv -----
// ----------------------------------------------------------------------------
// acmad_pkg
// Shared types and constants of the current mean-abs-deviation block.
// ----------------------------------------------------------------------------
`default_nettype none

package acmad_pkg;

  localparam int WL_W       = 11;  // window_len register width
  localparam int SCALE_W    = 16;  // scale_q8 register width
  localparam int OUT_W      = 16;  // current_ma width
  localparam int FRAC_W     = 8;   // fraction bits of the running averages
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [WL_W-1:0]    WINDOW_RST = 11'd64;
  localparam logic [SCALE_W-1:0] SCALE_RST  = 16'd6250;
  localparam logic [OUT_W-1:0]   OUT_MAX    = 16'hFFFF;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LEN = 8'd0,
    CFG_SCALE_Q8   = 8'd1
  } cfg_reg_t;

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// ----- design/ac_current_mean_abs_deviation.sv -----
// ----------------------------------------------------------------------------
// ac_current_mean_abs_deviation
// Running mean absolute deviation of a current-sensor ADC stream, in mA.
// ----------------------------------------------------------------------------
// usage:
//   in_*  : one raw ADC sample per item, in_tdata[SAMPLE_BITS-1:0]
//   out_* : one current_ma item per sample once warm-up is over
//   cfg_* : register writes, index 0 window_len (N), index 1 scale_q8 (Q8.8);
//           write only while the block is idle, cfg_ready is always high
// the block keeps a sample count, a running mean with weight 1/N and a
// running mean of |mean - sample|; samples up to 2N-1 give no item
// timing: one sample is worked at a time; in_tready is high only in idle.
//   each running-average update is one multiply plus one pass of the shared
//   divider (one quotient bit per cycle); a sample that yields an item runs
//   both updates, the scale multiply and the saturation step from accept to
//   the next accept; early warm-up samples are shorter
// latency: the item appears in the output register on the cycle the
//   sample's work ends; out_tdata holds until taken
// stall: the output register lets the next sample be accepted while an item
//   waits; a finished item stalls the sequencer only if the register is full
// reset (rst_n, synchronous): count and averages cleared, N = 64, scale 6250
// ----------------------------------------------------------------------------
`default_nettype none

module ac_current_mean_abs_deviation #(
  parameter int SAMPLE_BITS = 12,   // 8 .. 16
  parameter int MAX_WINDOW  = 1024  // 4 .. 4096
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // input channel
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]     in_tdata,   // sample, zero padding
  // result channel
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  output logic [acmad_pkg::OUT_W-1:0]               out_tdata,  // current_ma
  // configuration channel
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [acmad_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [acmad_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import acmad_pkg::*;

  localparam int NW    = $clog2(MAX_WINDOW + 1);        // effective N
  localparam int AVG_W = SAMPLE_BITS + FRAC_W;          // Q8 sample and averages
  localparam int NUM_W = AVG_W + NW;                    // avg*(N-1)+x
  localparam int CNT_W = $clog2(2 * MAX_WINDOW + 2);    // count incl. increment
  localparam int MB_W  = (NW > SCALE_W) ? NW : SCALE_W; // multiplier b operand
  localparam int CW    = (NW > WL_W) ? NW : WL_W;       // clamp compare width
  localparam int PW    = AVG_W + MB_W;                  // product width

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,    // avg * (N-1)
    S_LOAD,   // add sample, start divider
    S_DIV,    // wait for quotient
    S_SCALE,  // dev_avg * scale
    S_SAT     // saturate into output register
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [WL_W-1:0]    window_len_r, window_len_nxt;
  logic [SCALE_W-1:0] scale_r, scale_nxt;

  // model state
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [AVG_W-1:0]   mean_r, mean_nxt;
  logic [AVG_W-1:0]   dev_avg_r, dev_avg_nxt;

  // working registers
  logic               phase_r, phase_nxt;  // 0: mean update, 1: deviation update
  logic [AVG_W-1:0]   x_r, x_nxt;          // sample in Q8
  logic [AVG_W-1:0]   a_r, a_nxt;          // average being updated
  logic [AVG_W-1:0]   b_r, b_nxt;          // new value folded in
  logic [PW-1:0]      prod_r, prod_nxt;
  logic               out_tvalid_r, out_tvalid_nxt;
  logic [OUT_W-1:0]   out_tdata_r, out_tdata_nxt;

  // effective window and derived compares
  logic [CW-1:0]      wl_ext;
  logic [CW-1:0]      n_ext;
  logic [NW-1:0]      n;
  logic [CNT_W-1:0]   n_cnt;
  logic [CNT_W-1:0]   n2_cnt;
  logic [CNT_W-1:0]   cnt_inc;

  // shared multiplier
  logic [AVG_W-1:0]   mul_a;
  logic [MB_W-1:0]    mul_b;

  // divider
  logic               div_start;
  logic [NUM_W-1:0]   div_num;
  logic [AVG_W-1:0]   div_quo;
  div_stat_t          div_stat;

  logic [AVG_W-1:0]   dev;
  logic [AVG_W-1:0]   scaled;
  logic [OUT_W-1:0]   sat_val;

  // clamp window_len to [2, MAX_WINDOW]
  always_comb begin
    wl_ext = CW'(window_len_r);
    if (wl_ext < CW'(2)) begin
      n_ext = CW'(2);
    end else if (wl_ext > CW'(MAX_WINDOW)) begin
      n_ext = CW'(MAX_WINDOW);
    end else begin
      n_ext = wl_ext;
    end
    n       = n_ext[NW-1:0];
    n_cnt   = CNT_W'(n);
    n2_cnt  = CNT_W'({n, 1'b0});
    cnt_inc = cnt_r + CNT_W'(1);
  end

  // one multiplier serves the average weight and the output scale
  assign mul_a = (state_r == S_SCALE) ? dev_avg_r : a_r;
  assign mul_b = (state_r == S_SCALE) ? MB_W'(scale_r) : MB_W'(n - NW'(1));

  assign div_start = (state_r == S_LOAD);
  assign div_num   = NUM_W'(prod_r) + NUM_W'(b_r);

  acmad_div #(
    .QW (AVG_W),
    .DW (NW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (n),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  // deviation from the freshly updated mean
  assign dev = (div_quo >= x_r) ? (div_quo - x_r) : (x_r - div_quo);

  // Q8 * Q8.8 -> drop 16 bits, saturate
  assign scaled  = prod_r[AVG_W+15:16];
  assign sat_val = (scaled > AVG_W'(OUT_MAX)) ? OUT_MAX : scaled[OUT_W-1:0];

  always_comb begin
    state_nxt      = state_r;
    window_len_nxt = window_len_r;
    scale_nxt      = scale_r;
    cnt_nxt        = cnt_r;
    mean_nxt       = mean_r;
    dev_avg_nxt    = dev_avg_r;
    phase_nxt      = phase_r;
    x_nxt          = x_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    prod_nxt       = prod_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;

    if (cfg_valid) begin
      case (cfg_index)
        CFG_WINDOW_LEN: window_len_nxt = cfg_data[WL_W-1:0];
        CFG_SCALE_Q8:   scale_nxt      = cfg_data[SCALE_W-1:0];
        default:        ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          x_nxt   = {in_tdata[SAMPLE_BITS-1:0], {FRAC_W{1'b0}}};
          cnt_nxt = cnt_inc;
          if (cnt_inc == CNT_W'(1)) begin
            // first sample loads the mean directly
            mean_nxt = {in_tdata[SAMPLE_BITS-1:0], {FRAC_W{1'b0}}};
          end else begin
            a_nxt     = mean_r;
            b_nxt     = {in_tdata[SAMPLE_BITS-1:0], {FRAC_W{1'b0}}};
            phase_nxt = 1'b0;
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        prod_nxt  = PW'(mul_a * mul_b);
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_stat.done) begin
          if (!phase_r) begin
            mean_nxt = div_quo;
            if (cnt_r < n_cnt) begin
              state_nxt = S_IDLE;
            end else begin
              // deviation average is seeded when the count hits N
              a_nxt     = (cnt_r == n_cnt) ? dev : dev_avg_r;
              b_nxt     = dev;
              phase_nxt = 1'b1;
              state_nxt = S_MUL;
            end
          end else begin
            dev_avg_nxt = div_quo;
            if (cnt_r >= n2_cnt) begin
              cnt_nxt   = n2_cnt;
              state_nxt = S_SCALE;
            end else begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      S_SCALE: begin
        prod_nxt  = PW'(mul_a * mul_b);
        state_nxt = S_SAT;
      end
      S_SAT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = sat_val;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      window_len_r <= WINDOW_RST;
      scale_r      <= SCALE_RST;
      cnt_r        <= '0;
      mean_r       <= '0;
      dev_avg_r    <= '0;
      phase_r      <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      window_len_r <= window_len_nxt;
      scale_r      <= scale_nxt;
      cnt_r        <= cnt_nxt;
      mean_r       <= mean_nxt;
      dev_avg_r    <= dev_avg_nxt;
      phase_r      <= phase_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      x_r          <= x_nxt;
      a_r          <= a_nxt;
      b_r          <= b_nxt;
      prod_r       <= prod_nxt;
      out_tdata_r  <= out_tdata_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign cfg_ready  = 1'b1;

`ifndef NO_ASSERTIONS
  // count is held at 2N, one above it while a sample is being worked
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(2 * MAX_WINDOW + 1))
    else $error("sample count beyond 2*MAX_WINDOW+1");

  // a new item only comes out of the saturation step
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_nxt && !(out_tvalid_r && !out_tready)) |-> state_r == S_SAT)
    else $error("output item written outside saturation step");

  // the divider finishes only while the sequencer waits on it
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> state_r == S_DIV)
    else $error("divider done outside wait state");

  // divider is never restarted while busy
  a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");
`endif

endmodule

`default_nettype wire

// ----- design/acmad_div.sv -----
// ----------------------------------------------------------------------------
// acmad_div
// Iterative restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module acmad_div #(
  parameter int QW = 20,  // quotient bits, quotient known to fit
  parameter int DW = 11   // divisor bits
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [QW+DW-1:0]      dividend,
  input  wire logic [DW-1:0]         divisor,
  output logic      [QW-1:0]         quotient,
  output acmad_pkg::div_stat_t       stat
);
  import acmad_pkg::*;

  localparam int SW = $clog2(QW + 1);

  logic          busy_r;
  logic          done_r;
  logic [SW-1:0] step_r;
  logic [DW-1:0] rem_r;
  logic [QW-1:0] quo_r;
  logic [DW-1:0] den_r;
  logic [DW+1:0] trial;
  logic          fits;

  // partial remainder with the next dividend bit, minus the divisor
  always_comb begin
    trial = {1'b0, rem_r, quo_r[QW-1]} - {2'b00, den_r};
    fits  = ~trial[DW+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= SW'(QW);
      end else if (busy_r) begin
        step_r <= step_r - SW'(1);
        if (step_r == SW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: upper dividend bits stay below the divisor, so QW steps suffice
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[QW+DW-1:QW];
      quo_r <= dividend[QW-1:0];
      den_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? trial[DW-1:0] : {rem_r[DW-2:0], quo_r[QW-1]};
      quo_r <= {quo_r[QW-2:0], fits};
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

`default_nettype wire
